// ===== src/vrbd_pkg.sv =====
// ----------------------------------------------------------------------------
// vrbd_pkg: shared types and constants for the visibility bitmap decoder
// word layout, field widths and the decode state and result records
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vrbd_pkg;

   // coding layout
   localparam int WORD_BITS        = 8;
   localparam int LITERAL_BITS     = 7;
   localparam int SHORT_COUNT_BITS = 6;
   localparam int RUN_GRANULARITY  = 8;
   localparam int MAX_AREAS        = 4096;

   localparam int RUN_FLAG_BIT  = WORD_BITS - 1;
   localparam int LONG_FLAG_BIT = WORD_BITS - 2;

   // fixed field widths
   localparam int CODE_WORD_W = 8;
   localparam int AREA_W      = 13;
   localparam int CHUNK_W     = 7;
   localparam int CHUNK_POS_W = 12;

   // derived widths
   localparam int POS_BITS = $clog2(MAX_AREAS + 1);
   localparam int RUN_BITS = WORD_BITS + SHORT_COUNT_BITS;
   localparam int ADV_BITS = RUN_BITS + 2 + $clog2(RUN_GRANULARITY + 1);

   // apb register map
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] AREA_COUNT_ADDR = '0;

   typedef struct packed {
      logic [POS_BITS-1:0]         bit_position;
      logic                        long_run_pending;
      logic [SHORT_COUNT_BITS-1:0] pending_run_low;
   } dec_state_type;

   typedef struct packed {
      logic [CHUNK_W-1:0]     chunk_bits;
      logic [CHUNK_POS_W-1:0] chunk_position;
      logic                   chunk_valid;
      logic                   stream_done;
   } dec_result_type;

endpackage

// ===== src/vrbd_req_if.sv =====
// ----------------------------------------------------------------------------
// vrbd_req_if: code word channel
// valid/ready channel carrying one code word and its stream start flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vrbd_req_if import vrbd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CODE_WORD_W-1:0] code_word;
   logic                   start_stream;

   modport source(output valid, output code_word, output start_stream, input ready);
   modport sink(input valid, input code_word, input start_stream, output ready);
endinterface

// ===== src/vrbd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// vrbd_rsp_if: decoded chunk channel
// valid/ready channel carrying one decoded chunk and the done flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vrbd_rsp_if import vrbd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CHUNK_W-1:0]     chunk_bits;
   logic [CHUNK_POS_W-1:0] chunk_position;
   logic                   chunk_valid;
   logic                   stream_done;

   modport source(output valid, output chunk_bits, output chunk_position,
                  output chunk_valid, output stream_done, input ready);
   modport sink(input valid, input chunk_bits, input chunk_position,
                input chunk_valid, input stream_done, output ready);
endinterface

// ===== src/vrbd_decode.sv =====
// ----------------------------------------------------------------------------
// vrbd_decode: one-word decode step
// next position, long run bookkeeping and literal chunk for one code word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrbd_decode import vrbd_pkg::*; (
   input  logic [CODE_WORD_W-1:0] code_word,
   input  logic                   start_stream,
   input  logic [POS_BITS-1:0]    limit,
   input  dec_state_type          state_cur,
   output dec_state_type          state_nxt,
   output dec_result_type         result
);

   logic [WORD_BITS-1:0]    word;
   logic [POS_BITS-1:0]     pos;
   logic                    pending;
   logic [POS_BITS-1:0]     room;
   logic                    active;
   logic [RUN_BITS-1:0]     run_long;
   logic [RUN_BITS-1:0]     run_short;
   logic [RUN_BITS-1:0]     run_sel;
   logic [ADV_BITS-1:0]     run_amount;
   logic [ADV_BITS-1:0]     amount;
   logic                    do_adv;
   logic [POS_BITS-1:0]     pos_adv;
   logic [LITERAL_BITS-1:0] lit;
   logic [POS_BITS-1:0]     new_pos;

   assign word = WORD_BITS'(code_word);

   always_comb begin
      // start of stream wipes the position and any waiting run
      pos     = start_stream ? '0 : state_cur.bit_position;
      pending = start_stream ? 1'b0 : state_cur.long_run_pending;
      if (pos > limit) begin
         pos = limit;
      end
      room   = limit - pos;
      active = (pos < limit);

      run_long  = RUN_BITS'({word, (start_stream ? SHORT_COUNT_BITS'(0)
                                                 : state_cur.pending_run_low)});
      run_short = RUN_BITS'(word) & ((RUN_BITS'(1) << SHORT_COUNT_BITS) - RUN_BITS'(1));
      run_sel   = pending ? run_long : run_short;
      run_amount = (ADV_BITS'(run_sel) + ADV_BITS'(1)) * ADV_BITS'(RUN_GRANULARITY);

      // literal bits at or past the end read as zero
      for (int i = 0; i < LITERAL_BITS; i++) begin
         lit[i] = word[i % WORD_BITS] && (i < WORD_BITS) && (POS_BITS'(i) < room);
      end

      state_nxt.bit_position     = pos;
      state_nxt.long_run_pending = pending;
      state_nxt.pending_run_low  = start_stream ? '0 : state_cur.pending_run_low;
      result.chunk_bits     = '0;
      result.chunk_position = '0;
      result.chunk_valid    = 1'b0;
      amount = '0;
      do_adv = 1'b0;

      if (active) begin
         if (pending) begin
            state_nxt.long_run_pending = 1'b0;
            state_nxt.pending_run_low  = '0;
            amount = run_amount;
            do_adv = 1'b1;
         end else if (word[RUN_FLAG_BIT]) begin
            if (word[LONG_FLAG_BIT]) begin
               state_nxt.long_run_pending = 1'b1;
               state_nxt.pending_run_low  = run_short[SHORT_COUNT_BITS-1:0];
            end else begin
               amount = run_amount;
               do_adv = 1'b1;
            end
         end else begin
            result.chunk_bits     = CHUNK_W'(lit);
            result.chunk_position = CHUNK_POS_W'(pos);
            result.chunk_valid    = 1'b1;
            amount = ADV_BITS'(LITERAL_BITS);
            do_adv = 1'b1;
         end
      end

      // saturating advance
      pos_adv = (amount >= ADV_BITS'(room)) ? limit : POS_BITS'(ADV_BITS'(pos) + amount);
      new_pos = do_adv ? pos_adv : pos;
      state_nxt.bit_position = new_pos;
      result.stream_done = (new_pos >= limit);
   end

endmodule

// ===== src/visibility_rle_bitmap_decoder.sv =====
// ----------------------------------------------------------------------------
// visibility_rle_bitmap_decoder: run-length coded visibility bitmap decoder
// a word passes through the input register and then the result register before it shows on the rsp channel
// throughput: one word per cycle while the rsp channel does not stall, kept up by the position update loop
// the input register takes a new word while a finished chunk waits downstream
// reset: synchronous, clears position, pending run, area count and valids
// no memory, so no clearing pass after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module visibility_rle_bitmap_decoder import vrbd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   vrbd_req_if.sink              req_bus,
   vrbd_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // configuration
   logic [AREA_W-1:0]      area_count_ff;
   logic [AREA_W-1:0]      area_count_in;
   logic                   csr_write;
   logic [POS_BITS-1:0]    limit;

   // input register
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [CODE_WORD_W-1:0] in_word_ff;
   logic                   in_start_ff;

   // decode state and result register
   dec_state_type          state_ff;
   dec_state_type          state_in;
   dec_state_type          state_nxt;
   dec_result_type         result;
   dec_result_type         out_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;

   logic                   take_in;
   logic                   advance;
   logic                   move;

   // ---------------------------------------------------------------- csr
   // single register, area_count at byte address zero
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr == AREA_COUNT_ADDR);
   assign area_count_in = csr_write ? pwdata[AREA_W-1:0] : area_count_ff;
   assign prdata = (paddr == AREA_COUNT_ADDR) ? CSR_DATA_W'(area_count_ff) : '0;

   // area count above the map size behaves as the map size
   assign limit = (32'(area_count_ff) > 32'(MAX_AREAS)) ? POS_BITS'(MAX_AREAS)
                                                         : POS_BITS'(area_count_ff);

   // ---------------------------------------------------------------- handshake
   // result register frees up when empty or drained this cycle
   assign advance = !out_valid_ff || rsp_bus.ready;
   assign move    = in_valid_ff && advance;
   // the input register refills as soon as its word moves on
   assign req_bus.ready = !in_valid_ff || advance;
   assign take_in = req_bus.valid && req_bus.ready;

   assign in_valid_in  = take_in ? 1'b1 : (move ? 1'b0 : in_valid_ff);
   assign out_valid_in = move ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   // ---------------------------------------------------------------- decode
   vrbd_decode u_decode (
      .code_word    (in_word_ff),
      .start_stream (in_start_ff),
      .limit        (limit),
      .state_cur    (state_ff),
      .state_nxt    (state_nxt),
      .result       (result)
   );

   // position only moves when a word goes through to the result register
   assign state_in = move ? state_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         area_count_ff <= '0;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         area_count_ff <= area_count_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         state_ff      <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_in) begin
         in_word_ff  <= req_bus.code_word;
         in_start_ff <= req_bus.start_stream;
      end
      if (move) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.chunk_bits     = out_ff.chunk_bits;
   assign rsp_bus.chunk_position = out_ff.chunk_position;
   assign rsp_bus.chunk_valid    = out_ff.chunk_valid;
   assign rsp_bus.stream_done    = out_ff.stream_done;

   // ---------------------------------------------------------------- checks
   // position never runs past the map size
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      32'(state_ff.bit_position) <= 32'(MAX_AREAS))
      else $error("bit position beyond map size");

   // a chunk without literal bits carries zero bits and zero position
   a_empty_chunk: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.chunk_valid) |->
      (out_ff.chunk_bits == '0 && out_ff.chunk_position == '0))
      else $error("empty chunk has stray payload");

   // a word leaving the input register lands in the result register
   a_move_lands: assert property (@(posedge clock) disable iff (reset)
      move |=> out_valid_ff)
      else $error("decoded word lost");

   // a stalled word stays in the input register
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled word dropped");

endmodule
